FILE: design/esp_pkg.sv
package esp_pkg;

  localparam int unsigned ScaleW = 16;
  localparam int unsigned NormW  = 31;
  localparam int unsigned SqW    = 2 * NormW;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RootW  = 33;
  localparam int unsigned ProdW  = NormW + ScaleW;
  localparam int unsigned NumW   = ProdW + 1;
  localparam int unsigned QuotW  = ScaleW;
  localparam int unsigned PointW = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegScaleX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScaleY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScaleZ = 2'd2;

  // Per-item sideband that travels alongside the arithmetic.
  typedef struct packed {
    logic [2:0][ScaleW-1:0] scale;
    logic [2:0][NormW-1:0]  a;
    logic [2:0]             neg;
    logic                   zero_dir;
    logic                   degen;
  } side_t;

endpackage

FILE: design/esp_norm.sv
module esp_norm #(
  parameter int unsigned DIR_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [2:0][DIR_BITS-1:0]               dir_i,
  input  logic [2:0][esp_pkg::ScaleW-1:0]        scale_i,
  output logic                                   valid_o,
  output logic [esp_pkg::SumW-1:0]               ww_o,
  output esp_pkg::side_t                         side_o
);
  import esp_pkg::*;

  localparam int unsigned AW   = DIR_BITS + ScaleW;
  localparam int unsigned PW   = $clog2(AW);

  // Stage 1: magnitudes and signs.
  logic [2:0][DIR_BITS-1:0] mag_d, mag1_q;
  logic [2:0]               neg1_q;
  logic                     zero1_q;
  logic [2:0][ScaleW-1:0]   s1_q;
  logic                     v1_q;

  // Stage 2: exact scaled magnitudes.
  logic [2:0][AW-1:0]     a2_q;
  logic [2:0]             neg2_q;
  logic                   zero2_q;
  logic [2:0][ScaleW-1:0] s2_q;
  logic                   v2_q;

  // Stage 3: leading-one position of the largest component.
  logic [AW-1:0]          max_d;
  logic [PW-1:0]          pos_d, pos3_q;
  logic [2:0][AW-1:0]     a3_q;
  logic [2:0]             neg3_q;
  logic                   zero3_q, degen3_q;
  logic [2:0][ScaleW-1:0] s3_q;
  logic                   v3_q;

  // Stage 4: normalised components.
  logic [PW:0]            shamt;
  logic [2:0][NormW-1:0]  an_d;
  side_t                  side4_q;
  logic                   v4_q;

  // Stage 5: squares.
  logic [2:0][SqW-1:0]    sq5_q;
  side_t                  side5_q;
  logic                   v5_q;

  // Stage 6: sum of squares.
  logic [SumW-1:0]        ww6_q;
  side_t                  side6_q;
  logic                   v6_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = dir_i[k][DIR_BITS-1] ? (~dir_i[k] + 1'b1) : dir_i[k];
    end
  end

  always_comb begin
    max_d = a2_q[0];
    if (a2_q[1] > max_d) max_d = a2_q[1];
    if (a2_q[2] > max_d) max_d = a2_q[2];
    pos_d = '0;
    for (int i = 0; i < AW; i++) begin
      if (max_d[i]) pos_d = PW'(i);
    end
  end

  assign shamt = {1'b0, pos3_q} + 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      an_d[k] = NormW'({a3_q[k], {NormW{1'b0}}} >> shamt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      for (int k = 0; k < 3; k++) begin
        neg1_q[k] <= dir_i[k][DIR_BITS-1];
        a2_q[k]   <= AW'(mag1_q[k]) * AW'(s1_q[k]);
        sq5_q[k]  <= SqW'(side4_q.a[k]) * SqW'(side4_q.a[k]);
      end
      zero1_q <= (dir_i == '0);
      s1_q    <= scale_i;

      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      s2_q    <= s1_q;

      a3_q     <= a2_q;
      pos3_q   <= pos_d;
      neg3_q   <= neg2_q;
      zero3_q  <= zero2_q;
      degen3_q <= !zero2_q && (max_d == '0);
      s3_q     <= s2_q;

      side4_q.scale    <= s3_q;
      side4_q.a        <= an_d;
      side4_q.neg      <= neg3_q;
      side4_q.zero_dir <= zero3_q;
      side4_q.degen    <= degen3_q;

      side5_q <= side4_q;

      ww6_q   <= SumW'(sq5_q[0]) + SumW'(sq5_q[1]) + SumW'(sq5_q[2]);
      side6_q <= side5_q;
    end
  end

  assign valid_o = v6_q;
  assign ww_o    = ww6_q;
  assign side_o  = side6_q;

endmodule

FILE: design/esp_sqrt.sv
module esp_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [esp_pkg::SumW-1:0]     x_i,
  input  esp_pkg::side_t               side_i,
  output logic                         valid_o,
  output logic [esp_pkg::RootW-1:0]    root_o,
  output esp_pkg::side_t               side_o
);
  import esp_pkg::*;

  localparam int unsigned Steps = SumW / 2;

  logic [Steps:0]  vld;
  logic [SumW-1:0] rem  [Steps+1];
  logic [SumW-1:0] res  [Steps+1];
  side_t           side [Steps+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = x_i;
  assign res[0]  = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [SumW-1:0] Bit = SumW'(1) << (SumW - 2 - 2 * k);
    logic [SumW-1:0] trial;
    logic            take;
    logic [SumW-1:0] rem_d, res_d;

    assign trial = res[k] + Bit;
    assign take  = rem[k] >= trial;
    assign rem_d = take ? (rem[k] - trial) : rem[k];
    assign res_d = take ? ((res[k] >> 1) + Bit) : (res[k] >> 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= rem_d;
        res[k+1]  <= res_d;
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = vld[Steps];
  assign root_o  = res[Steps][RootW-1:0];
  assign side_o  = side[Steps];

endmodule

FILE: design/esp_div.sv
module esp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [esp_pkg::RootW-1:0]         root_i,
  input  esp_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [2:0][esp_pkg::QuotW-1:0]    quot_o,
  output esp_pkg::side_t                    side_o
);
  import esp_pkg::*;

  localparam int unsigned Steps = QuotW;

  // Product stage.
  logic [2:0][ProdW-1:0] prod_q;
  logic [RootW-1:0]      rootp_q;
  side_t                 sidep_q;
  logic                  vp_q;

  // Bit-per-stage long division; the quotient fits in QuotW bits because a <= r.
  logic [Steps:0]           vld;
  logic [2:0][RootW-1:0]    rem  [Steps+1];
  logic [2:0][QuotW-1:0]    low  [Steps+1];
  logic [2:0][QuotW-1:0]    quo  [Steps+1];
  logic [RootW-1:0]         rt   [Steps+1];
  side_t                    side [Steps+1];

  logic [2:0][NumW-1:0] num_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = NumW'(prod_q[k]) + NumW'(rootp_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q   <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en_i) begin
      vp_q   <= valid_i;
      vld[0] <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= ProdW'(side_i.a[k]) * ProdW'(side_i.scale[k]);
        rem[0][k] <= RootW'(num_d[k][NumW-1:QuotW]);
        low[0][k] <= num_d[k][QuotW-1:0];
      end
      rootp_q <= root_i;
      sidep_q <= side_i;
      quo[0]  <= '0;
      rt[0]   <= rootp_q;
      side[0] <= sidep_q;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [2:0][RootW:0]   trial;
    logic [2:0]            take;
    logic [2:0][RootW-1:0] rem_d;
    logic [2:0][QuotW-1:0] quo_d;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rem[j][k], low[j][k][QuotW-1-j]};
        take[k]  = trial[k] >= {1'b0, rt[j]};
        rem_d[k] = take[k] ? RootW'(trial[k] - {1'b0, rt[j]}) : RootW'(trial[k]);
        quo_d[k] = {quo[j][k][QuotW-2:0], take[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (en_i) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[j+1]  <= rem_d;
        quo[j+1]  <= quo_d;
        low[j+1]  <= low[j];
        rt[j+1]   <= rt[j];
        side[j+1] <= side[j];
      end
    end
  end

  assign valid_o = vld[Steps];
  assign quot_o  = quo[Steps];
  assign side_o  = side[Steps];

endmodule

FILE: design/ellipsoid_support_point_core.sv
// Each accepted input item goes through esp_norm, esp_sqrt, esp_div and the output register to the master side.
// Throughput: one item per cycle unless the output stalls; the square root has 32 stages, the division loop 16.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and sets every
// scale register to 1.0 (256 in Q8.8).
module ellipsoid_support_point_core #(
  parameter int unsigned DIR_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [esp_pkg::CfgIdxW-1:0]            cfg_idx_i,
  input  logic [esp_pkg::ScaleW-1:0]             cfg_data_i,
  // Direction items: dir_x, dir_y, dir_z from the lowest bit up.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((3*DIR_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // Support point items: point_x, point_y, point_z from the lowest bit up.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((3*esp_pkg::PointW+7)/8)*8-1:0] m_axis_tdata,
  // degenerate flag.
  output logic                                   m_axis_tuser
);
  import esp_pkg::*;

  localparam int unsigned OutW = ((3 * PointW + 7) / 8) * 8;

  // The whole pipeline advances together. It moves whenever the output register is
  // empty or its item is being taken, so a stall freezes every stage in place.
  logic en;

  logic [ScaleW-1:0] scale_x_q, scale_y_q, scale_z_q;

  logic [2:0][DIR_BITS-1:0] dir;
  logic [2:0][ScaleW-1:0]   scales;

  logic            nv;
  logic [SumW-1:0] ww;
  side_t           nside;

  logic             sv;
  logic [RootW-1:0] root;
  side_t            sside;

  logic                  dv;
  logic [2:0][QuotW-1:0] quot;
  side_t                 dside;

  logic [2:0][PointW-1:0] pt_d, pt_q;
  logic                   degen_d, degen_q;
  logic                   out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Scale registers; writes beyond the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= ScaleW'(256);
      scale_y_q <= ScaleW'(256);
      scale_z_q <= ScaleW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScaleX: scale_x_q <= cfg_data_i;
        RegScaleY: scale_y_q <= cfg_data_i;
        RegScaleZ: scale_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dir[0] = s_axis_tdata[DIR_BITS-1:0];
  assign dir[1] = s_axis_tdata[2*DIR_BITS-1:DIR_BITS];
  assign dir[2] = s_axis_tdata[3*DIR_BITS-1:2*DIR_BITS];

  assign scales[0] = scale_x_q;
  assign scales[1] = scale_y_q;
  assign scales[2] = scale_z_q;

  // Scaling by the semi-axes, normalisation that puts the largest component into [2^30, 2^31), and the sum of squares.
  esp_norm #(
    .DIR_BITS (DIR_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid && s_axis_tready),
    .dir_i   (dir),
    .scale_i (scales),
    .valid_o (nv),
    .ww_o    (ww),
    .side_o  (nside)
  );

  // Floor square root of the sum of squares, one result bit per stage.
  esp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv),
    .x_i     (ww),
    .side_i  (nside),
    .valid_o (sv),
    .root_o  (root),
    .side_o  (sside)
  );

  // Rounded quotient a*s / r for the three axes side by side.
  esp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv),
    .root_i  (root),
    .side_i  (sside),
    .valid_o (dv),
    .quot_o  (quot),
    .side_o  (dside)
  );

  // A zero direction returns the x semi-axis; a direction that the scales wipe out
  // returns the origin with the degenerate flag. Otherwise each magnitude takes the
  // sign of its direction component.
  always_comb begin
    degen_d = 1'b0;
    if (dside.zero_dir) begin
      pt_d[0] = PointW'(dside.scale[0]);
      pt_d[1] = '0;
      pt_d[2] = '0;
    end else if (dside.degen) begin
      pt_d    = '0;
      degen_d = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        pt_d[k] = dside.neg[k] ? (PointW'(0) - PointW'(quot[k])) : PointW'(quot[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q    <= pt_d;
      degen_q <= degen_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(pt_q);
  assign m_axis_tuser  = degen_q;

endmodule
